// ===== design/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared widths, defaults and controller/datapath interface types for the
// point leader clustering core.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int COORD_W        = 24;   // Q11.12 coordinate
	localparam int POINT_W        = 2 * COORD_W;
	localparam int RES_W          = 16;
	localparam int LIM_W          = RES_W + 1;   // 2 * resolution
	localparam int THR_W          = 2 * LIM_W;   // (2 * resolution)^2
	localparam int DIFF_W         = COORD_W;     // |a - b| fits in 24 bits
	localparam int SQ_W           = 2 * DIFF_W;
	localparam int DIST_W         = SQ_W + 1;
	localparam int IDX_W          = 6;
	localparam int LABEL_W        = 6;
	localparam int TOTAL_W        = 7;
	localparam int MAX_POINTS_DEF = 64;
	localparam logic [RES_W-1:0] RES_RESET = 16'd205;

	// controller -> datapath
	typedef struct packed {
		logic load;       // input item accepted
		logic start;      // begin clustering pass
		logic skip;       // current point already labeled
		logic seed_rd;    // read seed coordinates
		logic seed_cap;   // capture seed, open cluster
		logic scan;       // issue candidate read
		logic seed_done;  // close cluster, advance seed
		logic emit_rd;    // read next label for output
		logic clear;      // reset set state
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic i_end;
		logic i_labeled;
		logic j_end;
		logic pipe_empty;
		logic k_end;
		logic pend;
		logic can_load;
	} sts_t;

endpackage

// ===== design/point_leader_clustering_core.sv =====
// ----------------------------------------------------------------------------
// point_leader_clustering_core
// Greedy leader clustering of up to MAX_POINTS 2-D Q11.12 points.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one point per item, one item per
//    cycle while loading. Points beyond MAX_POINTS are dropped and flagged.
//  - An item with last_point set closes the set; in_ready then stays low
//    through clustering and result emission.
//  - Clustering: each unlabeled point in load order becomes a seed (read,
//    then captured), then every later point is streamed through one compare
//    pipeline, one per cycle, after which the end of the scan is seen and the
//    pipeline drains. Labeled points are skipped. The single point-store
//    read port and the one distance unit bound the clustering speed.
//  - Output channel (out_valid/out_ready): one result per stored point in
//    load order, one per cycle when not stalled, via the label read and the
//    output register. A stall holds the output register and pauses the label
//    reads; nothing is lost. cluster_total and final_label mark the last one.
//  - cfg_valid/cfg_data writes cell_resolution (always ready); write only
//    while the block is idle.
//  - Reset returns to loading with an empty set; resolution resets to 205.
// ----------------------------------------------------------------------------
module point_leader_clustering_core #(
	parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [plc_pkg::RES_W-1:0]           cfg_data,
	// point input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [plc_pkg::COORD_W-1:0]  point_x,
	input  logic signed [plc_pkg::COORD_W-1:0]  point_y,
	input  logic                                last_point,
	// label output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [plc_pkg::IDX_W-1:0]           point_index,
	output logic [plc_pkg::LABEL_W-1:0]         cluster_label,
	output logic [plc_pkg::TOTAL_W-1:0]         cluster_total,
	output logic                                final_label,
	output logic                                points_dropped
);
	import plc_pkg::*;

	cmd_t cmd;   // sequencer commands
	sts_t sts;   // counters and pipeline status

	// the resolution register takes a write in any cycle
	assign cfg_ready = 1'b1;

	plc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (last_point),
		.sts        (sts),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	plc_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.point_x        (point_x),
		.point_y        (point_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.point_index    (point_index),
		.cluster_label  (cluster_label),
		.cluster_total  (cluster_total),
		.final_label    (final_label),
		.points_dropped (points_dropped)
	);

endmodule

// ===== design/plc_ram.sv =====
// ----------------------------------------------------------------------------
// plc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module plc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/plc_ctrl.sv =====
// ----------------------------------------------------------------------------
// plc_ctrl
// Sequencer: load, seed search, candidate scan, drain, result emission.
// ----------------------------------------------------------------------------
module plc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_point,
	input  plc_pkg::sts_t sts,
	output logic          in_ready,
	output plc_pkg::cmd_t cmd
);
	import plc_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEEK,
		ST_SEED,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && last_point) begin
					cmd.start = 1'b1;
					state_d   = ST_SEEK;
				end
			end
			ST_SEEK: begin
				if (sts.i_end) begin
					state_d = ST_EMIT;
				end else if (sts.i_labeled) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.seed_rd = 1'b1;
					state_d     = ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed_cap = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.j_end) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					cmd.seed_done = 1'b1;
					state_d       = ST_SEEK;
				end
			end
			ST_EMIT: begin
				cmd.emit_rd = !sts.k_end && (!sts.pend || sts.can_load);
				if (sts.k_end && !sts.pend) begin
					cmd.clear = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_LOAD);

endmodule

// ===== design/plc_dpath.sv =====
// ----------------------------------------------------------------------------
// plc_dpath
// Point and label stores, distance pipeline, counters and output register.
// ----------------------------------------------------------------------------
module plc_dpath #(
	parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  plc_pkg::cmd_t                       cmd,
	output plc_pkg::sts_t                       sts,
	input  logic                                cfg_valid,
	input  logic [plc_pkg::RES_W-1:0]           cfg_data,
	input  logic signed [plc_pkg::COORD_W-1:0]  point_x,
	input  logic signed [plc_pkg::COORD_W-1:0]  point_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [plc_pkg::IDX_W-1:0]           point_index,
	output logic [plc_pkg::LABEL_W-1:0]         cluster_label,
	output logic [plc_pkg::TOTAL_W-1:0]         cluster_total,
	output logic                                final_label,
	output logic                                points_dropped
);
	import plc_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	// set state
	logic [RES_W-1:0]      res_q;
	logic [THR_W-1:0]      thr_q;
	logic [CW-1:0]         held_q;
	logic                  ovf_q;
	logic [CW-1:0]         clusters_q;
	logic [CW-1:0]         i_q;
	logic [CW-1:0]         j_q;
	logic [CW-1:0]         k_q;
	logic [MAX_POINTS-1:0] lab_vld_q;
	logic [COORD_W-1:0]    sx_q;
	logic [COORD_W-1:0]    sy_q;

	// distance pipeline
	logic              v_s1, v_s2, v_s3;
	logic [AW-1:0]     tag_s1, tag_s2, tag_s3;
	logic [DIFF_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;

	// emission
	logic              pend_q;
	logic [AW-1:0]     eidx_q;
	logic              efin_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  pidx_q;
	logic [LABEL_W-1:0] lab_q;
	logic [TOTAL_W-1:0] tot_q;
	logic              fin_q;
	logic              drop_q;

	logic               full;
	logic               can_load;
	logic               join_hit;
	logic [LIM_W-1:0]   lim;
	logic [POINT_W-1:0] pt_rdata;
	logic [LABEL_W-1:0] lab_rdata;
	logic [COORD_W-1:0] cx, cy;
	logic [COORD_W:0]   ddx, ddy;
	logic [COORD_W:0]   adx, ady;
	logic [DIST_W-1:0]  dist_sum;

	assign full     = (held_q == CW'(MAX_POINTS));
	assign can_load = !out_valid_q || out_ready;
	assign lim      = {res_q, 1'b0};

	plc_ram #(
		.WIDTH (POINT_W),
		.DEPTH (MAX_POINTS)
	) u_pt_ram (
		.clk   (clk),
		.we    (cmd.load && !full),
		.waddr (held_q[AW-1:0]),
		.wdata ({point_x, point_y}),
		.re    (cmd.seed_rd || cmd.scan),
		.raddr (cmd.seed_rd ? i_q[AW-1:0] : j_q[AW-1:0]),
		.rdata (pt_rdata)
	);

	plc_ram #(
		.WIDTH (LABEL_W),
		.DEPTH (MAX_POINTS)
	) u_lab_ram (
		.clk   (clk),
		.we    (cmd.seed_cap || join_hit),
		.waddr (cmd.seed_cap ? i_q[AW-1:0] : tag_s3),
		.wdata (LABEL_W'(clusters_q)),
		.re    (cmd.emit_rd),
		.raddr (k_q[AW-1:0]),
		.rdata (lab_rdata)
	);

	// stage 1 -> 2: absolute coordinate differences
	assign cx  = pt_rdata[POINT_W-1:COORD_W];
	assign cy  = pt_rdata[COORD_W-1:0];
	assign ddx = {cx[COORD_W-1], cx} - {sx_q[COORD_W-1], sx_q};
	assign ddy = {cy[COORD_W-1], cy} - {sy_q[COORD_W-1], sy_q};
	assign adx = ddx[COORD_W] ? -ddx : ddx;
	assign ady = ddy[COORD_W] ? -ddy : ddy;

	// stage 3: sum, compare, join
	assign dist_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign join_hit = v_s3 && !lab_vld_q[tag_s3] && (dist_sum <= DIST_W'(thr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q      <= RES_RESET;
			held_q     <= '0;
			ovf_q      <= 1'b0;
			clusters_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			lab_vld_q  <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			pend_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				res_q <= cfg_data;
			end
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					lab_vld_q[held_q[AW-1:0]] <= 1'b0;
					held_q <= held_q + CW'(1);
				end
			end
			if (cmd.start) begin
				i_q        <= '0;
				k_q        <= '0;
				clusters_q <= '0;
			end
			if (cmd.skip) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.seed_cap) begin
				lab_vld_q[i_q[AW-1:0]] <= 1'b1;
				j_q <= i_q + CW'(1);
			end
			if (cmd.scan) begin
				j_q <= j_q + CW'(1);
			end
			if (join_hit) begin
				lab_vld_q[tag_s3] <= 1'b1;
			end
			if (cmd.seed_done) begin
				i_q        <= i_q + CW'(1);
				clusters_q <= clusters_q + CW'(1);
			end

			v_s1 <= cmd.scan;
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			// emission: one label read in flight, output register behind it
			if (cmd.emit_rd) begin
				k_q <= k_q + CW'(1);
			end
			if (cmd.emit_rd) begin
				pend_q <= 1'b1;
			end else if (pend_q && can_load) begin
				pend_q <= 1'b0;
			end
			if (pend_q && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.clear) begin
				held_q     <= '0;
				ovf_q      <= 1'b0;
				clusters_q <= '0;
				lab_vld_q  <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			thr_q <= lim * lim;
		end
		if (cmd.seed_cap) begin
			sx_q <= cx;
			sy_q <= cy;
		end
		tag_s1 <= j_q[AW-1:0];
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		dx_s2  <= adx[DIFF_W-1:0];
		dy_s2  <= ady[DIFF_W-1:0];
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		if (cmd.emit_rd) begin
			eidx_q <= k_q[AW-1:0];
			efin_q <= ((k_q + CW'(1)) == held_q);
		end
		if (pend_q && can_load) begin
			pidx_q <= IDX_W'(eidx_q);
			lab_q  <= lab_rdata;
			tot_q  <= efin_q ? TOTAL_W'(clusters_q) : '0;
			fin_q  <= efin_q;
			drop_q <= ovf_q;
		end
	end

	assign sts.i_end      = (i_q == held_q);
	assign sts.i_labeled  = lab_vld_q[i_q[AW-1:0]];
	assign sts.j_end      = (j_q == held_q);
	assign sts.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign sts.k_end      = (k_q == held_q);
	assign sts.pend       = pend_q;
	assign sts.can_load   = can_load;

	assign out_valid      = out_valid_q;
	assign point_index    = pidx_q;
	assign cluster_label  = lab_q;
	assign cluster_total  = tot_q;
	assign final_label    = fin_q;
	assign points_dropped = drop_q;

	// seed capture only with the distance pipeline drained
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seed_cap |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("seed captured while candidates in flight");

	// candidates always lie after the current seed
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (CW'(tag_s3) > i_q))
		else $error("candidate at or before seed");

	// store count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(MAX_POINTS))
		else $error("point count over capacity");

	// last result of a set reports at least one cluster
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fin_q) |-> (tot_q != '0))
		else $error("final result with zero clusters");

	// a read label is taken into the output register before the next one lands
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_rd && pend_q |-> can_load)
		else $error("label read overruns output register");

endmodule
